>>> rtl/aes_ctr_pkg.sv
// ----------------------------------------------------------------------------
// aes_ctr_pkg - shared types, constants and byte functions
// S-box table, GF(2^8) doubling and the control bundles of the AES-128 CTR
// core.
// ----------------------------------------------------------------------------
package aes_ctr_pkg;

  localparam int BlockW    = 128;
  localparam int HalfW     = 64;
  localparam int NumRounds = 10;
  localparam int NumRk     = NumRounds + 1;   // round keys held in the store
  localparam int RkAw      = 4;               // bits to address NumRk entries
  localparam int CntW      = 5;
  localparam int CfgIdxW   = 2;

  localparam logic [CntW-1:0] FullBlock = 5'd16;
  localparam logic [7:0]      RconInit  = 8'h01;
  localparam logic [7:0]      GfPoly    = 8'h1b;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIvHigh  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegIvLow   = 2'd3;

  typedef logic [BlockW-1:0] block_t;

  // key schedule control
  typedef struct packed {
    logic load;   // take the cipher key, reset rcon
    logic step;   // advance to the next round key
  } kexp_ctrl_t;

  // round unit control
  typedef struct packed {
    logic first;  // initial key addition only
    logic last;   // final round, no MixColumns
  } rnd_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
  endfunction

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] blk_byte(input block_t b, input int i);
    return b[BlockW-1-8*i -: 8];
  endfunction

endpackage

>>> rtl/aes128_ctr_keystream_xor.sv
// ----------------------------------------------------------------------------
// aes128_ctr_keystream_xor - AES-128 counter-mode keystream XOR
// Encrypts a 128-bit counter with a shared round unit, XORs the keystream
// into each data word, masks bytes past the valid count and bumps the counter.
//
//   channel | ports                          | contents
//   --------+--------------------------------+--------------------------------
//   in      | in_tvalid/in_tready/in_tdata   | data block, byte count
//           | in_tuser                       | start of message
//   out     | out_tvalid/out_tready/out_tdata| masked result block
//   cfg     | cfg_we/cfg_index/cfg_wdata     | key and IV, write only
//
// A word runs the initial key addition plus ten rounds through the single
// round unit, one per cycle. Round keys come from an 11-entry store written
// as the key schedule steps alongside the first word of a message. The next
// word is taken on the cycle its predecessor finishes while the output side
// keeps up. A full output register stalls the core after its last round
// until it drains. rst_n clears control, counter and configuration; the
// round key store is not cleared.
// ----------------------------------------------------------------------------
module aes128_ctr_keystream_xor
  import aes_ctr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [135:0]       in_tdata,   // pad, byte_count, data_high, data_low
  input  logic               in_tuser,   // start_message
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [127:0]       out_tdata,  // out_high, out_low
  // configuration
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [HalfW-1:0]   cfg_wdata
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  localparam logic [RkAw-1:0] LastRnd = RkAw'(NumRounds);

  logic [1:0]      state_r, state_nxt;
  logic [RkAw-1:0] rnd_r, rnd_nxt;
  logic            start_r;
  block_t          data_r;
  logic [CntW-1:0] cnt_r;
  block_t          st_r, st_nxt;
  block_t          ctr_r, ctr_nxt;
  logic [HalfW-1:0] key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic            out_vld_r;
  block_t          out_dat_r;

  logic            in_acc, out_free, fin_rnd, done_go, ram_we;
  kexp_ctrl_t      kx_ctrl;
  rnd_ctrl_t       rd_ctrl;
  block_t          kx_key, ram_key, rkey, rnd_out, ks, masked;
  logic [CntW-1:0] nvalid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      iv_hi_r  <= '0;
      iv_lo_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeyHigh: key_hi_r <= cfg_wdata;
        RegKeyLow:  key_lo_r <= cfg_wdata;
        RegIvHigh:  iv_hi_r  <= cfg_wdata;
        RegIvLow:   iv_lo_r  <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // handshake and finish conditions
  assign out_free  = !out_vld_r || out_tready;
  assign fin_rnd   = (state_r == StRun) && (rnd_r == LastRnd);
  assign done_go   = (fin_rnd || (state_r == StHold)) && out_free;
  assign in_tready = (state_r == StIdle) || done_go;
  assign in_acc    = in_tvalid && in_tready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = '0;
    case (state_r)
      StIdle: begin
        if (in_acc) begin
          state_nxt = StRun;
        end
      end
      StRun: begin
        if (rnd_r != LastRnd) begin
          rnd_nxt = rnd_r + 1'b1;
        end else if (in_acc) begin
          state_nxt = StRun;
        end else if (done_go) begin
          state_nxt = StIdle;
        end else begin
          state_nxt = StHold;
        end
      end
      StHold: begin
        if (in_acc) begin
          state_nxt = StRun;
        end else if (done_go) begin
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      rnd_r   <= '0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      if (in_acc) begin
        start_r <= in_tuser;
      end
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r <= {in_tdata[63:0], in_tdata[127:64]};
      cnt_r  <= in_tdata[132:128];
    end
  end

  // key schedule runs only for the first word of a message
  assign kx_ctrl.load = in_acc && in_tuser;
  assign kx_ctrl.step = (state_r == StRun) && start_r;

  aes_ctr_kexp u_kexp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (kx_ctrl),
    .key_in ({key_hi_r, key_lo_r}),
    .rkey   (kx_key)
  );

  // round key store, read one round ahead
  assign ram_we = (state_r == StRun) && start_r;

  aes_ctr_ram #(
    .Width (BlockW),
    .Depth (NumRk)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rnd_r),
    .wdata (kx_key),
    .raddr (rnd_nxt),
    .rdata (ram_key)
  );

  assign rkey = start_r ? kx_key : ram_key;

  // shared round unit
  assign rd_ctrl.first = (rnd_r == '0);
  assign rd_ctrl.last  = (rnd_r == LastRnd);

  aes_ctr_round u_round (
    .ctrl   (rd_ctrl),
    .st_in  (rd_ctrl.first ? ctr_r : st_r),
    .rkey   (rkey),
    .st_out (rnd_out)
  );

  assign st_nxt = (state_r == StRun) ? rnd_out : st_r;

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  // counter: reload on a new message, step once per finished word
  always_comb begin
    ctr_nxt = ctr_r;
    if (in_acc && in_tuser) begin
      ctr_nxt = {iv_hi_r, iv_lo_r};
    end else if (done_go) begin
      ctr_nxt = ctr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else begin
      ctr_r <= ctr_nxt;
    end
  end

  // keystream XOR and byte mask
  assign ks     = fin_rnd ? rnd_out : st_r;
  assign nvalid = (cnt_r > FullBlock) ? FullBlock : cnt_r;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      masked[BlockW-1-8*i -: 8] = (CntW'(i) < nvalid) ?
                                  (blk_byte(data_r, i) ^ blk_byte(ks, i)) : 8'h00;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (done_go) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_dat_r <= {masked[63:0], masked[127:64]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

  // checks
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == StRun) && (rnd_r == '0))
    else $error("core not started after accepted word");

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= LastRnd)
    else $error("round index past last round");

  a_ram_we_start: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> start_r && (state_r == StRun))
    else $error("round key store written outside key schedule");

  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (done_go && !in_acc) |=> ctr_r == $past(ctr_r) + 1'b1)
    else $error("counter not stepped after finished word");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(done_go))
    else $error("result presented without finished word");

endmodule

>>> rtl/aes_ctr_ram.sv
// ----------------------------------------------------------------------------
// aes_ctr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module aes_ctr_ram #(
  parameter int Width = 128,
  parameter int Depth = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/aes_ctr_kexp.sv
// ----------------------------------------------------------------------------
// aes_ctr_kexp - AES-128 key schedule, one round key per step
// Holds the current round key and rcon; the sequencer loads the cipher key
// and steps it once per round while a new message's first word runs.
// ----------------------------------------------------------------------------
module aes_ctr_kexp
  import aes_ctr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  kexp_ctrl_t ctrl,
  input  block_t     key_in,
  output block_t     rkey
);

  block_t     key_r,  key_nxt;
  logic [7:0] rcon_r, rcon_nxt;
  logic [7:0] t0, t1, t2, t3;
  logic [31:0] tw, n0, n1, n2, n3;

  // RotWord, SubWord and rcon on the last word of the current key
  always_comb begin
    t0 = SBOX[blk_byte(key_r, 13)] ^ rcon_r;
    t1 = SBOX[blk_byte(key_r, 14)];
    t2 = SBOX[blk_byte(key_r, 15)];
    t3 = SBOX[blk_byte(key_r, 12)];
    tw = {t0, t1, t2, t3};
    n0 = key_r[127:96] ^ tw;
    n1 = key_r[95:64]  ^ n0;
    n2 = key_r[63:32]  ^ n1;
    n3 = key_r[31:0]   ^ n2;
  end

  // next key / rcon
  always_comb begin
    key_nxt  = key_r;
    rcon_nxt = rcon_r;
    if (ctrl.load) begin
      key_nxt  = key_in;
      rcon_nxt = RconInit;
    end else if (ctrl.step) begin
      key_nxt  = {n0, n1, n2, n3};
      rcon_nxt = gf_dbl(rcon_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcon_r <= RconInit;
    end else begin
      rcon_r <= rcon_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign rkey = key_r;

endmodule

>>> rtl/aes_ctr_round.sv
// ----------------------------------------------------------------------------
// aes_ctr_round - shared AES round unit
// SubBytes, ShiftRows, MixColumns and AddRoundKey on one 128-bit state;
// also does the initial key addition and the final round without mixing.
// ----------------------------------------------------------------------------
module aes_ctr_round
  import aes_ctr_pkg::*;
(
  input  rnd_ctrl_t ctrl,
  input  block_t    st_in,
  input  block_t    rkey,
  output block_t    st_out
);

  logic [7:0] sub [16];
  logic [7:0] mix [16];
  logic [7:0] a0, a1, a2, a3, all;
  block_t     rnd_res;

  // SubBytes + ShiftRows, state column-major
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        sub[c*4+w] = SBOX[blk_byte(st_in, ((c + w) % 4) * 4 + w)];
      end
    end
  end

  // MixColumns, skipped on the last round
  always_comb begin
    a0  = '0;
    a1  = '0;
    a2  = '0;
    a3  = '0;
    all = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = sub[c*4];
      a1  = sub[c*4+1];
      a2  = sub[c*4+2];
      a3  = sub[c*4+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (ctrl.last) begin
        mix[c*4]   = a0;
        mix[c*4+1] = a1;
        mix[c*4+2] = a2;
        mix[c*4+3] = a3;
      end else begin
        mix[c*4]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
        mix[c*4+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
        mix[c*4+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
        mix[c*4+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
      end
    end
  end

  // repack and add the round key
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rnd_res[BlockW-1-8*i -: 8] = mix[i];
    end
    st_out = ctrl.first ? (st_in ^ rkey) : (rnd_res ^ rkey);
  end

endmodule
